// File: hw/rtl/lsmm_pkg.sv
// Shared types and constants for the lidar sector min/mean block.
// Used by every module of the block but lsmm_ram; depends on nothing else.
`default_nettype none

package lsmm_pkg;

	localparam int DIST_W     = 15;
	localparam int RAW_DIST_W = 16;
	localparam int ANGLE_W    = 9;
	localparam int MEAN_W     = 19;
	localparam int COUNT_W    = 9;
	localparam int STATUS_W   = 2;
	localparam int FRAC_W     = 4;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	localparam logic [DIST_W-1:0] DIST_SAT = 15'd19999;
	localparam logic [DIST_W-1:0] MIN_NONE = 15'd20000;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ANGLE = 2'd1,
		ST_NO_DATA   = 2'd2
	} status_t;

	typedef enum logic {
		FN_STORE = 1'b0,
		FN_QUERY = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic store;
		logic load;
		logic walk;
		logic div_init;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic walk_done;
		logic skip_div;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lidar_sector_min_mean.sv
// Top level of the lidar sector min/mean block: stream ports, controller and datapath.
// Depends on lsmm_pkg, lsmm_ctrl, lsmm_dp (and through it lsmm_ram).
//
// Keeps one 15-bit distance per degree (ANGLE_COUNT entries, zero = no return) in a
// single-port-write, single-port-read RAM. A store item gives no result. A query item
// walks the sector one table entry per cycle through the RAM read port, then, unless a
// sector angle exceeds ANGLE_COUNT or the sector holds no nonzero entry, runs a
// restoring divider that makes one quotient bit per cycle. After reset a clearing pass
// writes zero to every entry, during which no item is taken. The result sits in
// an output register, so the next item is taken while a result still waits
// on m_axis_tready.
`default_nettype none

module lidar_sector_min_mean #(
	parameter int ANGLE_COUNT = 360
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// angle[8:0], distance[24:9], start_angle[33:25], end_angle[42:34], zero pad
	input  wire logic [lsmm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func
	input  wire logic                              s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// min_distance[14:0], mean_distance[33:15], valid_count[42:34], zero pad
	output logic [lsmm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// status
	output logic [lsmm_pkg::STATUS_W-1:0]          m_axis_tuser
);

	import lsmm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	logic [DIST_W-1:0]  min_distance;
	logic [MEAN_W-1:0]  mean_distance;
	logic [COUNT_W-1:0] valid_count;

	lsmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_func  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lsmm_dp #(
		.ANGLE_COUNT (ANGLE_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.angle         (s_axis_tdata[8:0]),
		.distance      (s_axis_tdata[24:9]),
		.start_angle   (s_axis_tdata[33:25]),
		.end_angle     (s_axis_tdata[42:34]),
		.out_ready     (m_axis_tready),
		.stat          (stat),
		.out_valid     (m_axis_tvalid),
		.status        (m_axis_tuser),
		.min_distance  (min_distance),
		.mean_distance (mean_distance),
		.valid_count   (valid_count)
	);

	assign m_axis_tdata = {5'd0, valid_count, mean_distance, min_distance};

endmodule

`default_nettype wire

// File: hw/rtl/lsmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lsmm_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 360
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/lsmm_ctrl.sv
// Controller state machine: clearing pass, item intake, sector walk, division, result.
// Depends on lsmm_pkg.
`default_nettype none

module lsmm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_func,
	output logic                 in_ready,
	input  wire lsmm_pkg::stat_t stat,
	output lsmm_pkg::cmd_t       cmd
);

	import lsmm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (stat.clr_last) state_d = S_IDLE;
			S_IDLE:  if (in_valid && in_func == FN_QUERY) state_d = S_WALK;
			S_WALK:  if (stat.walk_done) state_d = stat.skip_div ? S_DONE : S_DIV;
			S_DIV:   if (stat.div_done) state_d = S_DONE;
			S_DONE:  if (stat.out_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.store = in_valid && in_func == FN_STORE;
				cmd.load  = in_valid && in_func == FN_QUERY;
			end
			S_WALK: begin
				cmd.walk     = 1'b1;
				cmd.div_init = stat.walk_done && !stat.skip_div;
			end
			S_DIV:   cmd.div_step = 1'b1;
			S_DONE:  cmd.emit = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/lsmm_dp.sv
// Datapath: distance table, sector walk accumulators, serial divider, result register.
// Depends on lsmm_pkg and lsmm_ram.
`default_nettype none

module lsmm_dp #(
	parameter int ANGLE_COUNT = 360
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lsmm_pkg::cmd_t                    cmd,
	input  wire logic [lsmm_pkg::ANGLE_W-1:0]      angle,
	input  wire logic [lsmm_pkg::RAW_DIST_W-1:0]   distance,
	input  wire logic [lsmm_pkg::ANGLE_W-1:0]      start_angle,
	input  wire logic [lsmm_pkg::ANGLE_W-1:0]      end_angle,
	input  wire logic                              out_ready,
	output lsmm_pkg::stat_t                        stat,
	output logic                                   out_valid,
	output logic [lsmm_pkg::STATUS_W-1:0]          status,
	output logic [lsmm_pkg::DIST_W-1:0]            min_distance,
	output logic [lsmm_pkg::MEAN_W-1:0]            mean_distance,
	output logic [lsmm_pkg::COUNT_W-1:0]           valid_count
);

	import lsmm_pkg::*;

	localparam int IW      = $clog2(ANGLE_COUNT);
	localparam int NW      = $clog2(ANGLE_COUNT + 1);
	localparam int AXW     = (NW > ANGLE_W) ? NW : ANGLE_W;
	localparam int SUM_MAX = ANGLE_COUNT * 19999;
	localparam int SW      = $clog2(SUM_MAX + 1);
	localparam int QW      = SW + FRAC_W;
	localparam int DCW     = $clog2(QW + 1);

	localparam logic [AXW-1:0] AC_X     = AXW'(ANGLE_COUNT);
	localparam logic [IW-1:0]  IDX_LAST = IW'(ANGLE_COUNT - 1);

	logic [IW-1:0]     clr_idx_q;
	logic [IW-1:0]     idx_q;
	logic [NW-1:0]     rem_q;
	logic              rd_vld_s1;
	logic              bad_q;
	logic [NW-1:0]     cnt_q;
	logic [SW-1:0]     sum_q;
	logic [DIST_W-1:0] mn_q;
	logic [QW-1:0]     quo_q;
	logic [NW-1:0]     drem_q;
	logic [DCW-1:0]    dcnt_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [DIST_W-1:0] min_q;
	logic [MEAN_W-1:0] mean_q;
	logic [COUNT_W-1:0] count_q;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [DIST_W-1:0] ram_wdata;
	logic              ram_re;
	logic [DIST_W-1:0] ram_rdata;
	logic [DIST_W-1:0] sat_dist;
	logic [AXW-1:0]    s_x;
	logic [AXW-1:0]    e_x;
	logic [AXW-1:0]    len_x;
	logic              bad_d;
	logic [IW-1:0]     idx0;
	logic [NW:0]       rem_sh;
	logic [NW:0]       cnt_ext;
	logic              qbit;
	status_t           status_d;

	assign sat_dist = (distance > RAW_DIST_W'(DIST_SAT)) ? DIST_SAT : distance[DIST_W-1:0];

	always_comb begin
		if (cmd.clr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else begin
			ram_we    = cmd.store && (AXW'(angle) < AC_X);
			ram_waddr = IW'(angle);
			ram_wdata = sat_dist;
		end
	end

	assign ram_re = cmd.walk && rem_q != '0;

	lsmm_ram #(
		.WIDTH (DIST_W),
		.DEPTH (ANGLE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign s_x   = AXW'(start_angle);
	assign e_x   = AXW'(end_angle);
	assign bad_d = (s_x > AC_X) || (e_x > AC_X);
	assign len_x = (s_x > e_x) ? (AC_X - s_x + e_x) : (e_x - s_x);
	assign idx0  = (s_x == AC_X) ? '0 : IW'(s_x);

	assign cnt_ext = (NW + 1)'(cnt_q);
	assign rem_sh  = {drem_q, quo_q[QW-1]};
	assign qbit    = rem_sh >= cnt_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			rem_q     <= '0;
			rd_vld_s1 <= 1'b0;
			dcnt_q    <= '0;
			bad_q     <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			rd_vld_s1 <= ram_re;
			if (cmd.load) begin
				bad_q <= bad_d;
				rem_q <= bad_d ? '0 : NW'(len_x);
			end else if (ram_re) begin
				rem_q <= rem_q - 1'b1;
			end
			if (cmd.div_init) begin
				dcnt_q <= DCW'(QW);
			end else if (cmd.div_step && dcnt_q != '0) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= idx0;
			cnt_q <= '0;
			sum_q <= '0;
			mn_q  <= MIN_NONE;
		end else begin
			if (ram_re) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
			if (rd_vld_s1 && ram_rdata != '0) begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_q + SW'(ram_rdata);
				if (ram_rdata < mn_q) begin
					mn_q <= ram_rdata;
				end
			end
		end
		if (cmd.div_init) begin
			quo_q  <= {sum_q, FRAC_W'(0)};
			drem_q <= '0;
		end else if (cmd.div_step && dcnt_q != '0) begin
			drem_q <= qbit ? NW'(rem_sh - cnt_ext) : NW'(rem_sh);
			quo_q  <= {quo_q[QW-2:0], qbit};
		end
	end

	always_comb begin
		if (bad_q) begin
			status_d = ST_BAD_ANGLE;
		end else if (cnt_q == '0) begin
			status_d = ST_NO_DATA;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= status_d;
			min_q    <= (status_d == ST_OK) ? mn_q : MIN_NONE;
			mean_q   <= (status_d == ST_OK) ? MEAN_W'(quo_q) : '0;
			count_q  <= (status_d == ST_OK) ? COUNT_W'(cnt_q) : '0;
		end
	end

	assign stat.clr_last  = clr_idx_q == IDX_LAST;
	assign stat.walk_done = rem_q == '0 && !rd_vld_s1;
	assign stat.skip_div  = bad_q || cnt_q == '0;
	assign stat.div_done  = dcnt_q == '0;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign min_distance  = min_q;
	assign mean_distance = mean_q;
	assign valid_count   = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/lsmm_checker.sv
// Port-level checks for the lidar sector min/mean block, bound to its top level.
// Depends on lsmm_pkg and lidar_sector_min_mean.
`default_nettype none

module lsmm_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            s_axis_tuser,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [lsmm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [lsmm_pkg::STATUS_W-1:0]   m_axis_tuser
);

	import lsmm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result item changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_QUERY |=> !s_axis_tready)
		else $error("item taken while a query is in progress");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |->
			(m_axis_tuser == ST_BAD_ANGLE || m_axis_tuser == ST_NO_DATA) &&
			m_axis_tdata[14:0] == MIN_NONE && m_axis_tdata[47:15] == '0)
		else $error("failed query carries wrong fields");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_OK |->
			m_axis_tdata[14:0] != '0 && m_axis_tdata[14:0] <= DIST_SAT &&
			m_axis_tdata[47:43] == '0)
		else $error("good query minimum out of range");

endmodule

bind lidar_sector_min_mean lsmm_checker u_lsmm_checker (.*);

`default_nettype wire

// File: tb/sv/tb_lidar_sector_min_mean.sv
// Self-checking testbench for lidar_sector_min_mean: drives store and sector query items,
// predicts each query's status, min, mean and count from a local distance table.
// Depends on lsmm_pkg and the lidar_sector_min_mean RTL.
module tb_lidar_sector_min_mean;
	import lsmm_pkg::*;

	localparam int ANGLE_COUNT = 360;
	localparam int CYCLE_LIMIT = 1_200_000;
	localparam int RANDOM_ITEMS = 625;

	typedef struct {
		func_t                 op;
		logic [ANGLE_W-1:0]    angle;
		logic [RAW_DIST_W-1:0] sample;
		logic [ANGLE_W-1:0]    sa;
		logic [ANGLE_W-1:0]    ea;
	} scan_item_t;

	typedef struct {
		status_t            st;
		logic [DIST_W-1:0]  min_dist;
		logic [MEAN_W-1:0]  mean;
		logic [COUNT_W-1:0] cnt;
	} sector_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;

	logic [DIST_W-1:0] range_table [ANGLE_COUNT];
	scan_item_t        scan_items[$];
	sector_result_t    sector_results_due[$];
	scan_item_t        item_on_bus;
	sector_result_t    due;
	sector_result_t    want;
	int                items_taken = 0;
	int                errors = 0;
	int                cycles = 0;
	wire               no_gaps = (items_taken >= 250 && items_taken < 420);

	lidar_sector_min_mean #(
		.ANGLE_COUNT(ANGLE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) cycles++;

	function automatic bit apply_scan_item(input scan_item_t it, output sector_result_t r);
		int unsigned s, e, len, idx, sum, cnt, mn;
		r.st = ST_NO_DATA;
		r.min_dist = MIN_NONE;
		r.mean = '0;
		r.cnt = '0;
		if (it.op == FN_STORE) begin
			if (it.angle < ANGLE_COUNT)
				range_table[it.angle] = (it.sample > DIST_SAT) ? DIST_SAT :
					it.sample[DIST_W-1:0];
			return 1'b0;
		end
		s = it.sa;
		e = it.ea;
		if (s > ANGLE_COUNT || e > ANGLE_COUNT) begin
			r.st = ST_BAD_ANGLE;
			return 1'b1;
		end
		len = (s > e) ? ANGLE_COUNT - s + e : e - s;
		idx = (s >= ANGLE_COUNT) ? s - ANGLE_COUNT : s;
		sum = 0;
		cnt = 0;
		mn = MIN_NONE;
		for (int unsigned i = 0; i < len; i++) begin
			if (range_table[idx] != 0) begin
				cnt++;
				sum += range_table[idx];
				if (range_table[idx] < mn)
					mn = range_table[idx];
			end
			idx = (idx + 1 >= ANGLE_COUNT) ? 0 : idx + 1;
		end
		if (cnt != 0) begin
			r.st = ST_OK;
			r.min_dist = DIST_W'(mn);
			r.mean = MEAN_W'((sum << FRAC_W) / cnt);
			r.cnt = COUNT_W'(cnt);
		end
		return 1'b1;
	endfunction

	function automatic scan_item_t mk_store(input int unsigned ang, input int unsigned d);
		scan_item_t it;
		it.op = FN_STORE;
		it.angle = ANGLE_W'(ang);
		it.sample = RAW_DIST_W'(d);
		it.sa = ANGLE_W'($urandom_range(511));
		it.ea = ANGLE_W'($urandom_range(511));
		return it;
	endfunction

	function automatic scan_item_t mk_query(input int unsigned s, input int unsigned e);
		scan_item_t it;
		it.op = FN_QUERY;
		it.angle = ANGLE_W'($urandom_range(511));
		it.sample = RAW_DIST_W'($urandom_range(65535));
		it.sa = ANGLE_W'(s);
		it.ea = ANGLE_W'(e);
		return it;
	endfunction

	task automatic check_field(input string what, input logic [31:0] exp_v, input logic [31:0] got);
		if (got !== exp_v) begin
			$display("%0t: %s expected %0d got %0d", $time, what, exp_v, got);
			errors++;
		end
	endtask

	// driver: present the next pending item, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (apply_scan_item(item_on_bus, due))
					sector_results_due.push_back(due);
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (scan_items.size() != 0 && (no_gaps || $urandom_range(99) >= 23)) begin
					item_on_bus = scan_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'd0, item_on_bus.ea, item_on_bus.sa,
						item_on_bus.sample, item_on_bus.angle};
					s_axis_tuser <= item_on_bus.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (sector_results_due.size() == 0) begin
					$display("%0t: unexpected result, status %0d", $time, m_axis_tuser);
					errors++;
				end else begin
					want = sector_results_due.pop_front();
					check_field("status", want.st, m_axis_tuser);
					check_field("min_distance", want.min_dist, m_axis_tdata[14:0]);
					check_field("mean_distance", want.mean, m_axis_tdata[33:15]);
					check_field("valid_count", want.cnt, m_axis_tdata[42:34]);
				end
			end
			m_axis_tready <= no_gaps || ($urandom_range(99) >= 23);
		end
	end

	initial begin
		int unsigned roll, pick, ang, s, e;
		int unsigned d;

		// empty table, edges of the angle range, saturation, wrap, bad angles
		scan_items.push_back(mk_query(0, 360));
		scan_items.push_back(mk_store(0, 1));
		scan_items.push_back(mk_store(359, 65535));
		scan_items.push_back(mk_store(180, 20000));
		scan_items.push_back(mk_store(181, 19999));
		scan_items.push_back(mk_store(90, 0));
		scan_items.push_back(mk_store(360, 500));
		scan_items.push_back(mk_store(511, 700));
		scan_items.push_back(mk_query(0, 360));
		scan_items.push_back(mk_query(359, 1));
		scan_items.push_back(mk_query(360, 2));
		scan_items.push_back(mk_query(10, 360));
		scan_items.push_back(mk_query(360, 0));
		scan_items.push_back(mk_query(5, 5));
		scan_items.push_back(mk_query(361, 10));
		scan_items.push_back(mk_query(10, 361));
		scan_items.push_back(mk_query(511, 511));
		scan_items.push_back(mk_query(1, 0));
		scan_items.push_back(mk_query(182, 359));
		scan_items.push_back(mk_store(0, 0));
		scan_items.push_back(mk_query(0, 1));
		scan_items.push_back(mk_store(100, 12345));
		scan_items.push_back(mk_query(100, 101));
		scan_items.push_back(mk_query(0, 360));

		repeat (RANDOM_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 62) begin
				ang = ($urandom_range(9) == 0) ? $urandom_range(511, 360) : $urandom_range(359);
				pick = $urandom_range(9);
				d = (pick < 2) ? 0 :
					(pick < 3) ? $urandom_range(65535, 20000) :
					(pick < 4) ? $urandom_range(40, 1) :
					(pick < 5) ? $urandom_range(65535) : $urandom_range(19999, 1);
				scan_items.push_back(mk_store(ang, d));
			end else begin
				pick = $urandom_range(99);
				if (pick < 12) begin
					s = $urandom_range(511);
					e = $urandom_range(511);
				end else if (pick < 22) begin
					s = $urandom_range(360);
					e = s;
				end else if (pick < 60) begin
					s = $urandom_range(360);
					e = (s + $urandom_range(30)) % 361;
				end else begin
					s = $urandom_range(360);
					e = $urandom_range(360);
				end
				scan_items.push_back(mk_query(s, e));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while ((scan_items.size() != 0 || s_axis_tvalid || sector_results_due.size() != 0)
			&& cycles < CYCLE_LIMIT)
			@(negedge clk);

		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_lidar_sector_min_mean NOT OK");
		end else begin
			repeat (500) @(posedge clk);
			if (errors == 0)
				$display("tb_lidar_sector_min_mean OK");
			else
				$display("tb_lidar_sector_min_mean NOT OK");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lsmm_pkg.sv
hw/rtl/lsmm_ram.sv
hw/rtl/lsmm_ctrl.sv
hw/rtl/lsmm_dp.sv
hw/rtl/lidar_sector_min_mean.sv
hw/rtl/lsmm_checker.sv
tb/sv/tb_lidar_sector_min_mean.sv
